// ----- sv/handle_slot_table_core_assert.svh -----
// Assertion macros for the handle slot table core.
// Used by the top level only; depends on nothing else.
`ifndef HANDLE_SLOT_TABLE_CORE_ASSERT_SVH
`define HANDLE_SLOT_TABLE_CORE_ASSERT_SVH

`ifndef SYNTH
// Implication in the same cycle, disabled during reset.
`define HST_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Implication in the next cycle, disabled during reset.
`define HST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define HST_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define HST_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- sv/hst_pkg.sv -----
// Shared constants for the handle slot table core.
// No dependencies; imported by the top level.
`default_nettype none

package hst_pkg;

  // Default sizes.
  localparam int SLOTS_DEF       = 256;
  localparam int HANDLE_BITS_DEF = 24;

  // Port field widths.
  localparam int MODE_W   = 2;
  localparam int HPORT_W  = 24;
  localparam int VALUE_W  = 32;
  localparam int SPORT_W  = 8;
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 72;

  // Request codes.
  localparam logic [MODE_W-1:0] MODE_REG   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_UNREG = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LOOK  = 2'd2;

endpackage

`default_nettype wire

// ----- sv/hst_ram.sv -----
// Generic simple dual-port RAM with a registered read port.
// No dependencies.
`default_nettype none

module hst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- sv/handle_slot_table_core.sv -----
// Handle slot table core: issues, checks and removes handles in a hashed table.
// Depends on hst_pkg, hst_ram and handle_slot_table_core_assert.svh.
//
// Channel   Dir  Handshake             Payload
// in_       in   in_tvalid/in_tready   mode, handle, entry_value
// out_      out  out_tvalid/out_tready ok, handle_out, value_out, slot_index
//
// A lookup or unregister reads and checks the handle's home slot, found by
// masking when SLOTS is a power of two and otherwise by a reciprocal-multiply
// slot remainder in ST_MOD. A register probes k slots (1 to SLOTS); each
// probe is one read and check (ST_PROBE, ST_CHECK) through the table RAM read port.
// After reset a clearing pass over all slots empties the table; no item is
// accepted meanwhile. A result waiting on out_tready holds the next item.
`default_nettype none
`include "handle_slot_table_core_assert.svh"

module handle_slot_table_core
  import hst_pkg::*;
#(
  parameter int SLOTS       = SLOTS_DEF,
  parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // mode [1:0], handle [25:2], entry_value [57:26], zero fill [63:58]
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // ok [0], handle_out [24:1], value_out [56:25], slot_index [64:57], zero [71:65]
  output logic      [OUT_TDATA_W-1:0] out_tdata
);

  localparam int HB   = HANDLE_BITS;
  localparam int SB   = $clog2(SLOTS);
  localparam int RW   = 1 + HB + VALUE_W;
  localparam bit POW2 = (SLOTS & (SLOTS - 1)) == 0;

  // Reciprocal of SLOTS scaled by 2^(HB+SB), rounded up; exact for any handle.
  localparam int          MW      = HB + 1;
  localparam int          PW      = HB + MW;
  localparam int          QS      = HB + SB;
  localparam logic [63:0] RECIP   = ((64'd1 << QS) + 64'(SLOTS) - 64'd1) / 64'(SLOTS);
  localparam logic [MW-1:0] RECIP_M = RECIP[MW-1:0];

  // Sequencer states.
  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_MOD   = 3'd2;
  localparam logic [2:0] ST_READ  = 3'd3;
  localparam logic [2:0] ST_LCHK  = 3'd4;
  localparam logic [2:0] ST_PROBE = 3'd5;
  localparam logic [2:0] ST_CHECK = 3'd6;
  localparam logic [2:0] ST_DONE  = 3'd7;

  logic [2:0]         state_r, state_nxt;
  logic [MODE_W-1:0]  mode_r, mode_nxt;
  logic [HB-1:0]      key_r, key_nxt;
  logic [PW-1:0]      prod_r, prod_nxt;
  logic [VALUE_W-1:0] val_r, val_nxt;
  logic [HB-1:0]      cand_r, cand_nxt;
  logic [SB-1:0]      slot_r, slot_nxt;
  logic [SB-1:0]      tries_r, tries_nxt;
  logic               cnt_r, cnt_nxt;
  logic [HB:0]        next_handle_r, next_handle_nxt;
  logic [SB-1:0]      next_slot_r, next_slot_nxt;
  logic               res_ok_r, res_ok_nxt;
  logic [HB-1:0]      res_handle_r, res_handle_nxt;
  logic [VALUE_W-1:0] res_value_r, res_value_nxt;
  logic [SB-1:0]      res_slot_r, res_slot_nxt;
  logic               out_tvalid_r, out_tvalid_nxt;
  logic               out_ok_r;
  logic [HB-1:0]      out_handle_r;
  logic [VALUE_W-1:0] out_value_r;
  logic [SB-1:0]      out_slot_r;
  logic               out_load;

  logic               ram_we;
  logic [RW-1:0]      ram_wdata;
  logic [RW-1:0]      ram_rdata;
  logic               rd_valid;
  logic [HB-1:0]      rd_handle;
  logic [VALUE_W-1:0] rd_value;

  logic [MODE_W-1:0]  in_mode;
  logic [31:0]        in_handle_wide;
  logic [HB-1:0]      in_key;
  logic [31:0]        in_key_wide;
  logic [HB-1:0]      quot;
  logic [HB-1:0]      rem_h;
  logic [SB-1:0]      slot_inc;
  logic [HB:0]        cand_inc;
  logic               match;
  logic [31:0]        oh_wide;
  logic [31:0]        os_wide;

  // Table RAM: valid mark, stored handle and value per slot.
  hst_ram #(
    .WIDTH (RW),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_r),
    .wdata (ram_wdata),
    .raddr (slot_r),
    .rdata (ram_rdata)
  );

  assign rd_valid  = ram_rdata[RW-1];
  assign rd_handle = ram_rdata[RW-2 -: HB];
  assign rd_value  = ram_rdata[VALUE_W-1:0];

  // Input field unpacking; the handle is cut to the handle width.
  assign in_mode        = in_tdata[1:0];
  assign in_handle_wide = {8'b0, in_tdata[25:2]};
  assign in_key         = in_handle_wide[HB-1:0];
  assign in_key_wide    = 32'(in_key);

  // Shared step logic: slot remainder, slot increment and handle increment.
  assign quot     = HB'(prod_r >> QS);
  assign rem_h    = key_r - quot * HB'(SLOTS);
  assign slot_inc = (slot_r == SB'(SLOTS - 1)) ? '0 : slot_r + SB'(1);
  assign cand_inc = {1'b0, cand_r} + (HB+1)'(1);
  assign match    = rd_valid && (rd_handle == key_r);

  assign in_tready = (state_r == ST_IDLE);
  assign out_load  = (state_r == ST_DONE) && (!out_tvalid_r || out_tready);

  // Sequencer.
  always_comb begin
    state_nxt       = state_r;
    mode_nxt        = mode_r;
    key_nxt         = key_r;
    prod_nxt        = prod_r;
    val_nxt         = val_r;
    cand_nxt        = cand_r;
    slot_nxt        = slot_r;
    tries_nxt       = tries_r;
    cnt_nxt         = cnt_r;
    next_handle_nxt = next_handle_r;
    next_slot_nxt   = next_slot_r;
    res_ok_nxt      = res_ok_r;
    res_handle_nxt  = res_handle_r;
    res_value_nxt   = res_value_r;
    res_slot_nxt    = res_slot_r;
    ram_we          = 1'b0;
    ram_wdata       = '0;

    unique case (state_r)
      ST_CLEAR: begin
        ram_we = 1'b1;
        if (slot_r == SB'(SLOTS - 1)) begin
          slot_nxt  = '0;
          state_nxt = ST_IDLE;
        end else begin
          slot_nxt = slot_r + SB'(1);
        end
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          mode_nxt  = in_mode;
          key_nxt   = in_key;
          val_nxt   = in_tdata[57:26];
          cnt_nxt   = 1'b0;
          tries_nxt = '0;
          case (in_mode) inside
            MODE_REG: begin
              if (next_handle_r[HB]) begin
                cand_nxt = HB'(1);
                slot_nxt = SB'(1);
              end else begin
                cand_nxt = next_handle_r[HB-1:0];
                slot_nxt = next_slot_r;
              end
              state_nxt = ST_PROBE;
            end
            MODE_UNREG, MODE_LOOK: begin
              if (POW2) begin
                slot_nxt  = in_key_wide[SB-1:0];
                state_nxt = ST_READ;
              end else begin
                slot_nxt  = '0;
                state_nxt = ST_MOD;
              end
            end
            default: begin
              res_ok_nxt     = 1'b0;
              res_handle_nxt = '0;
              res_value_nxt  = '0;
              res_slot_nxt   = '0;
              state_nxt      = ST_DONE;
            end
          endcase
        end
      end
      ST_MOD: begin
        // Slot remainder: first handle times the reciprocal, then handle minus
        // quotient times SLOTS.
        if (!cnt_r) begin
          prod_nxt = PW'(key_r) * PW'(RECIP_M);
          cnt_nxt  = 1'b1;
        end else begin
          slot_nxt  = SB'(rem_h);
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_LCHK;
      end
      ST_LCHK: begin
        res_slot_nxt = slot_r;
        if (match) begin
          res_ok_nxt     = 1'b1;
          res_handle_nxt = key_r;
          res_value_nxt  = (mode_r == MODE_LOOK) ? rd_value : '0;
          ram_we         = (mode_r == MODE_UNREG);
        end else begin
          res_ok_nxt     = 1'b0;
          res_handle_nxt = '0;
          res_value_nxt  = '0;
        end
        state_nxt = ST_DONE;
      end
      ST_PROBE: begin
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (!rd_valid) begin
          // Free slot: claim it and move the running handle past it.
          ram_we          = 1'b1;
          ram_wdata       = {1'b1, cand_r, val_r};
          next_handle_nxt = cand_inc;
          next_slot_nxt   = slot_inc;
          res_ok_nxt      = 1'b1;
          res_handle_nxt  = cand_r;
          res_value_nxt   = '0;
          res_slot_nxt    = slot_r;
          state_nxt       = ST_DONE;
        end else if (tries_r == SB'(SLOTS - 1)) begin
          res_ok_nxt     = 1'b0;
          res_handle_nxt = '0;
          res_value_nxt  = '0;
          res_slot_nxt   = '0;
          state_nxt      = ST_DONE;
        end else begin
          tries_nxt = tries_r + SB'(1);
          if (cand_inc[HB]) begin
            cand_nxt = HB'(1);
            slot_nxt = SB'(1);
          end else begin
            cand_nxt = cand_inc[HB-1:0];
            slot_nxt = slot_inc;
          end
          state_nxt = ST_PROBE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output valid: set on a load, cleared when the item is taken.
  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (out_load) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_CLEAR;
      slot_r        <= '0;
      next_handle_r <= (HB+1)'(1);
      next_slot_r   <= SB'(1);
      out_tvalid_r  <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      slot_r        <= slot_nxt;
      next_handle_r <= next_handle_nxt;
      next_slot_r   <= next_slot_nxt;
      out_tvalid_r  <= out_tvalid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    mode_r       <= mode_nxt;
    key_r        <= key_nxt;
    prod_r       <= prod_nxt;
    val_r        <= val_nxt;
    cand_r       <= cand_nxt;
    tries_r      <= tries_nxt;
    cnt_r        <= cnt_nxt;
    res_ok_r     <= res_ok_nxt;
    res_handle_r <= res_handle_nxt;
    res_value_r  <= res_value_nxt;
    res_slot_r   <= res_slot_nxt;
    if (out_load) begin
      out_ok_r     <= res_ok_r;
      out_handle_r <= res_handle_r;
      out_value_r  <= res_value_r;
      out_slot_r   <= res_slot_r;
    end
  end

  // Output packing.
  assign oh_wide    = 32'(out_handle_r);
  assign os_wide    = 32'(out_slot_r);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {7'b0, os_wide[7:0], out_value_r, oh_wide[23:0], out_ok_r};

  // Checks.
  `HST_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_tvalid && in_tready, !in_tready)
  `HST_ASSERT_IMPL(a_no_out_in_clear, clk, rst_n, state_r == ST_CLEAR, !out_tvalid_r)
  `HST_ASSERT_IMPL(a_ok_handle_nonzero, clk, rst_n, out_tvalid_r && out_ok_r, out_handle_r != '0)

endmodule

`default_nettype wire
